### rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### rtl/bdp_sst_pkg.sv
// package with types and constants of the bdp slow start threshold block
`timescale 1ns / 1ps
package bdp_sst_pkg;

   localparam logic [30:0] RTT_NONE      = 31'h7fffffff;
   localparam logic [31:0] USEC_SCALE    = 32'd1000000;
   localparam logic [31:0] MIN_THRESHOLD = 32'd2;
   localparam int          DIV_STEPS     = 64;
   localparam int          DIV_CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      JOB_ACK_SKIP,
      JOB_ACK,
      JOB_QUERY_NONE,
      JOB_QUERY
   } job_type;

   typedef enum logic {
      OP_ACK   = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### rtl/bdp_sst_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface bdp_sst_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] rtt_sample_us;
   logic        [31:0] acked_count;
   logic        [31:0] window_now;

   modport source (output valid, opcode, rtt_sample_us, acked_count, window_now,
                   input ready);
   modport sink (input valid, opcode, rtt_sample_us, acked_count, window_now,
                 output ready);
endinterface

interface bdp_sst_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] threshold;
   logic [30:0] rtt_floor_us;
   logic [31:0] rate_filtered;
   logic [31:0] rate_instant;
   logic        sample_taken;

   modport source (output valid, threshold, rtt_floor_us, rate_filtered, rate_instant,
                   sample_taken, input ready);
   modport sink (input valid, threshold, rtt_floor_us, rate_filtered, rate_instant,
                 sample_taken, output ready);
endinterface

### rtl/bdp_sst_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bdp_sst_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                dividend,
   input  logic [31:0]                divisor,
   output logic [63:0]                quotient,
   output bdp_sst_pkg::div_stat_type  stat
);
   import bdp_sst_pkg::*;

   logic [63:0]          dq_ff, dq_in;
   logic [32:0]          rem_ff, rem_in;
   logic [31:0]          dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [32:0] rem_shift;
   logic [33:0] diff;
   logic        fits;

   always_comb begin
      rem_shift = {rem_ff[31:0], dq_ff[63]};
      diff      = {1'b0, rem_shift} - {2'b00, dsr_ff};
      fits      = !diff[33];

      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[62:0], fits};
         rem_in = fits ? diff[32:0] : rem_shift;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quotient  = dq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

### rtl/bdp_slow_start_threshold_top.sv
// Bandwidth-delay product slow start threshold block, top level.
// Requests arrive on req_chan (valid/ready). Opcode 0 is an ack sample
// (rtt in microseconds, packets acked); opcode 1 is a loss query carrying the
// congestion window. Every request gives exactly one response on rsp_chan
// with the threshold and the estimator state after the request.
// A valid ack sample and a query with an estimate each use one 32x32
// multiply and a 64-bit restoring divide on the shared divider, one quotient
// bit per cycle. An ignored ack sample or a query without an estimate skips
// the multiply and the divide and goes straight to the finish state.
// The block takes one request at a time; req_chan.ready is high only
// while the sequencer is idle, so a new request waits until the last one
// has left the sequencer; the divide path runs the 64 divider steps.
// The response sits in an output register; a new request is taken while it
// waits, and the next response waits in the sequencer until rsp_chan.ready.
// Reset (synchronous) clears the minimum rtt to 0x7fffffff and both rates to
// zero, drops any pending response and returns the sequencer to idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdp_slow_start_threshold_top (
   input  logic          clock,
   input  logic          reset,
   bdp_sst_req_if.sink   req_chan,
   bdp_sst_rsp_if.source rsp_chan
);
   import bdp_sst_pkg::*;

   state_type   state_ff, state_in;
   job_type     kind_ff, kind_in;
   job_type     kind_new;
   logic [30:0] rtt_ff, rtt_in;
   logic [31:0] pkts_ff, pkts_in;
   logic [31:0] win_ff, win_in;
   logic [63:0] prod_ff, prod_in;
   logic [30:0] floor_ff, floor_in;
   logic [31:0] smooth_ff, smooth_in;
   logic [31:0] last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] thr_ff, thr_in;
   logic        took_ff, took_in;

   logic         accept;
   logic         out_free;
   logic         finish;
   logic         ack_ok;
   logic         have_est;
   logic         is_ack_job;
   logic [31:0]  mul_a, mul_b;
   logic         div_start;
   logic [31:0]  div_divisor;
   logic [63:0]  div_quot;
   div_stat_type div_stat;
   logic [31:0]  half;
   logic [31:0]  bounded;
   logic [31:0]  rate_new;
   logic [31:0]  seven_old;
   logic [31:0]  filt_sum;

   bdp_sst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // job classification at accept
   always_comb begin
      ack_ok   = (req_chan.rtt_sample_us != 32'sd0) && !req_chan.rtt_sample_us[31]
                 && (req_chan.acked_count != 32'd0);
      have_est = (floor_ff != RTT_NONE) && (smooth_ff != 32'd0);
      if (req_chan.opcode == OP_ACK) begin
         kind_new = ack_ok ? JOB_ACK : JOB_ACK_SKIP;
      end else begin
         kind_new = have_est ? JOB_QUERY : JOB_QUERY_NONE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (kind_new == JOB_ACK || kind_new == JOB_QUERY) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MUL:    state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      div_start      = (state_ff == ST_LOAD);
      finish         = (state_ff == ST_FINISH) && out_free;
   end

   // datapath
   always_comb begin
      is_ack_job  = (kind_ff == JOB_ACK);
      mul_a       = is_ack_job ? pkts_ff : smooth_ff;
      mul_b       = is_ack_job ? USEC_SCALE : {1'b0, floor_ff};
      prod_in     = (state_ff == ST_MUL) ? mul_a * mul_b : prod_ff;
      div_divisor = is_ack_job ? {1'b0, rtt_ff} : USEC_SCALE;

      half = {1'b0, win_ff[31:1]};
      if (half < MIN_THRESHOLD) begin
         half = MIN_THRESHOLD;
      end

      // bdp bounded to 2 .. 4*window, upper bound wraps
      if (div_quot < 64'd2) begin
         bounded = MIN_THRESHOLD;
      end else if (div_quot > {30'd0, win_ff, 2'b00}) begin
         bounded = {win_ff[29:0], 2'b00};
      end else begin
         bounded = div_quot[31:0];
      end
      if (bounded < MIN_THRESHOLD) begin
         bounded = MIN_THRESHOLD;
      end

      rate_new  = div_quot[31:0];
      seven_old = {smooth_ff[28:0], 3'b000} - smooth_ff;
      filt_sum  = seven_old + rate_new;

      kind_in = accept ? kind_new : kind_ff;
      rtt_in  = accept ? req_chan.rtt_sample_us[30:0] : rtt_ff;
      pkts_in = accept ? req_chan.acked_count : pkts_ff;
      win_in  = accept ? req_chan.window_now : win_ff;

      floor_in     = floor_ff;
      smooth_in    = smooth_ff;
      last_in      = last_ff;
      thr_in       = thr_ff;
      took_in      = took_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (finish) begin
         rsp_valid_in = 1'b1;
         took_in      = 1'b0;
         case (kind_ff)
            JOB_ACK_SKIP:   thr_in = 32'd0;
            JOB_ACK: begin
               thr_in  = 32'd0;
               took_in = 1'b1;
               if (floor_ff == RTT_NONE || rtt_ff < floor_ff) begin
                  floor_in = rtt_ff;
               end
               last_in = rate_new;
               if (smooth_ff == 32'd0) begin
                  smooth_in = rate_new;
               end else begin
                  smooth_in = {3'b000, filt_sum[31:3]};
               end
            end
            JOB_QUERY_NONE: thr_in = half;
            JOB_QUERY:      thr_in = bounded;
            default:        thr_in = 32'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         floor_ff     <= RTT_NONE;
         smooth_ff    <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         floor_ff     <= floor_in;
         smooth_ff    <= smooth_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      rtt_ff  <= rtt_in;
      pkts_ff <= pkts_in;
      win_ff  <= win_in;
      prod_ff <= prod_in;
      thr_ff  <= thr_in;
      took_ff <= took_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.threshold     = thr_ff;
   assign rsp_chan.rtt_floor_us  = floor_ff;
   assign rsp_chan.rate_filtered = smooth_ff;
   assign rsp_chan.rate_instant  = last_ff;
   assign rsp_chan.sample_taken  = took_ff;

   `ASSERT_CLK(a_div_done_in_wait, clock, reset, div_stat.done |-> state_ff == ST_DIV, "divider done outside wait")
   `ASSERT_NEVER(a_div_restart, clock, reset, div_start && div_stat.busy, "divider started while busy")
   `ASSERT_CLK(a_div_nonzero, clock, reset, div_start |-> div_divisor != 32'd0, "divide by zero")
   `ASSERT_CLK(a_query_min, clock, reset, finish && (kind_ff == JOB_QUERY || kind_ff == JOB_QUERY_NONE) |-> thr_in >= MIN_THRESHOLD, "query threshold below two")
   `ASSERT_CLK(a_taken_no_thr, clock, reset, rsp_valid_ff && took_ff |-> thr_ff == 32'd0, "ack response with threshold")

endmodule

### test/bdp_sst_checker.sv
// checker that predicts and compares every response of the slow start threshold block
`timescale 1ns / 1ps
module bdp_sst_checker (
   input  logic   clock,
   input  logic   reset,
   bdp_sst_req_if req_mon,
   bdp_sst_rsp_if rsp_mon,
   output int     fail_count,
   output int     pending_count,
   output int     rsp_count,
   output int     taken_count
);
   import bdp_sst_pkg::*;

   typedef struct packed {
      logic [31:0] threshold;
      logic [30:0] rtt_floor_us;
      logic [31:0] rate_filtered;
      logic [31:0] rate_instant;
      logic        sample_taken;
   } sst_result_type;

   logic [30:0] floor_us;
   logic [31:0] smooth_rate;
   logic [31:0] last_rate;
   sst_result_type sst_results_q[$];

   function automatic sst_result_type step_estimator(input logic op, input logic [31:0] rtt,
                                                     input logic [31:0] pkts,
                                                     input logic [31:0] win);
      sst_result_type r;
      logic [63:0] rate_full;
      logic [63:0] bdp;
      logic [63:0] upper;
      logic [31:0] half;
      logic [31:0] target;
      logic [31:0] sum;
      r = '0;
      if (op == OP_ACK) begin
         if (rtt != 32'd0 && !rtt[31] && pkts != 32'd0) begin
            if (floor_us == RTT_NONE || rtt[30:0] < floor_us) floor_us = rtt[30:0];
            rate_full = (64'(pkts) * 64'(USEC_SCALE)) / 64'(rtt);
            last_rate = rate_full[31:0];
            if (smooth_rate == 32'd0) begin
               smooth_rate = last_rate;
            end else begin
               sum = 32'd7 * smooth_rate + last_rate;
               smooth_rate = sum >> 3;
            end
            r.sample_taken = 1'b1;
         end
      end else begin
         half = win >> 1;
         if (half < MIN_THRESHOLD) half = MIN_THRESHOLD;
         if (floor_us == RTT_NONE || smooth_rate == 32'd0) begin
            r.threshold = half;
         end else begin
            bdp = (64'(smooth_rate) * 64'(floor_us)) / 64'(USEC_SCALE);
            upper = 64'(win) << 2;
            if (bdp < 64'(MIN_THRESHOLD)) target = MIN_THRESHOLD;
            else if (bdp > upper) target = win << 2;
            else target = bdp[31:0];
            if (target < MIN_THRESHOLD) target = MIN_THRESHOLD;
            r.threshold = target;
         end
      end
      r.rtt_floor_us = floor_us;
      r.rate_filtered = smooth_rate;
      r.rate_instant = last_rate;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      sst_result_type want;
      if (reset) begin
         floor_us = RTT_NONE;
         smooth_rate = '0;
         last_rate = '0;
         sst_results_q.delete();
         fail_count = 0;
         rsp_count = 0;
         taken_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_count++;
            if (sst_results_q.size() == 0) begin
               report_mismatch("response with no request waiting", rsp_mon.threshold, '0);
            end else begin
               want = sst_results_q.pop_front();
               if (rsp_mon.threshold !== want.threshold)
                  report_mismatch("threshold", rsp_mon.threshold, want.threshold);
               if (rsp_mon.rtt_floor_us !== want.rtt_floor_us)
                  report_mismatch("rtt_floor_us", 32'(rsp_mon.rtt_floor_us),
                                  32'(want.rtt_floor_us));
               if (rsp_mon.rate_filtered !== want.rate_filtered)
                  report_mismatch("rate_filtered", rsp_mon.rate_filtered, want.rate_filtered);
               if (rsp_mon.rate_instant !== want.rate_instant)
                  report_mismatch("rate_instant", rsp_mon.rate_instant, want.rate_instant);
               if (rsp_mon.sample_taken !== want.sample_taken)
                  report_mismatch("sample_taken", 32'(rsp_mon.sample_taken),
                                  32'(want.sample_taken));
               if (want.sample_taken) taken_count++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            sst_results_q.push_back(step_estimator(req_mon.opcode, req_mon.rtt_sample_us,
                                                   req_mon.acked_count, req_mon.window_now));
      end
      pending_count <= sst_results_q.size();
   end

endmodule

### test/bdp_slow_start_threshold_top_test.sv
// stimulus and verdict for the bdp slow start threshold block
`timescale 1ns / 1ps
module bdp_slow_start_threshold_top_test;
   import bdp_sst_pkg::*;

   localparam int HOLD_CYCLES  = 500;
   localparam int PHASE_ITEMS  = 160;
   localparam int BURST_ITEMS  = 12;

   logic clock = 1'b0;
   logic reset;
   int   send_pct = 0;
   int   stall_pct = 0;
   int   hold_seq = 0;
   int   hold_seen = 0;
   int   ack_sent = 0;
   int   query_sent = 0;
   int   fail_count;
   int   pending_count;
   int   rsp_count;
   int   taken_count;

   bdp_sst_req_if req_chan ();
   bdp_sst_rsp_if rsp_chan ();

   bdp_slow_start_threshold_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bdp_sst_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rsp_count     (rsp_count),
      .taken_count   (taken_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response ready, with a long hold whenever hold_seq moves
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_request(input opcode_type op, input logic [31:0] rtt,
                               input logic [31:0] pkts, input logic [31:0] win);
      if ($urandom_range(99) < send_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.rtt_sample_us <= rtt;
      req_chan.acked_count <= pkts;
      req_chan.window_now <= win;
      do @(posedge clock); while (!req_chan.ready);
      if (op == OP_ACK) ack_sent++;
      else query_sent++;
   endtask

   function automatic logic [31:0] pick_rtt(input int phase);
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom_range(32'h7fffffff, 32'd1000000);
         4, 5, 6:    v = $urandom_range(32'd1000000, 32'd1000);
         7, 8:       v = $urandom_range(32'd999, 32'd1);
         default:    v = ($urandom_range(1) == 0) ? 32'h7fffffff : 32'd1;
      endcase
      // keep the rtt floor large in the early phases
      if (phase < 2 && v < 32'd1000000) v = v + 32'd1000000;
      return v;
   endfunction

   function automatic logic [31:0] pick_count();
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom_range(64, 1);
         4, 5:       v = $urandom_range(100000, 1);
         6, 7:       v = $urandom();
         8:          v = 32'hffffffff;
         default:    v = 32'd1;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_window();
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1, 2: v = $urandom_range(200, 0);
         3, 4, 5: v = $urandom();
         6, 7:    v = $urandom_range(32'h00100000, 0);
         default: begin
            case ($urandom_range(5))
               0:       v = 32'd0;
               1:       v = 32'd1;
               2:       v = 32'd2;
               3:       v = 32'h3fffffff;
               4:       v = 32'h40000000;
               default: v = 32'hffffffff;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send_random(input int phase);
      int          kind;
      logic [31:0] rtt;
      logic [31:0] pkts;
      logic [31:0] win;
      kind = $urandom_range(99);
      rtt = $urandom();
      pkts = $urandom();
      win = pick_window();
      if (kind < 55) begin
         send_request(OP_ACK, pick_rtt(phase), pick_count(), win);
      end else if (kind < 70) begin
         case ($urandom_range(2))
            0: rtt = 32'd0;
            1: rtt[31] = 1'b1;
            default: begin
               rtt = pick_rtt(phase);
               pkts = 32'd0;
            end
         endcase
         send_request(OP_ACK, rtt, pkts, win);
      end else begin
         send_request(OP_QUERY, rtt, pkts, win);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_ACK;
      req_chan.rtt_sample_us = '0;
      req_chan.acked_count = '0;
      req_chan.window_now = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // queries before any estimate
      send_request(OP_QUERY, 32'd0, 32'd0, 32'd0);
      send_request(OP_QUERY, 32'd0, 32'd0, 32'd5);
      send_request(OP_QUERY, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      // ignored samples
      send_request(OP_ACK, 32'd0, 32'd1, 32'd0);
      send_request(OP_ACK, 32'hffffffff, 32'd7, 32'hffffffff);
      send_request(OP_ACK, 32'h80000000, 32'hffffffff, 32'd0);
      send_request(OP_ACK, 32'd100, 32'd0, 32'd0);
      // largest rtt keeps the floor unset, zero rate leaves the filter empty
      send_request(OP_ACK, 32'h7fffffff, 32'd1, 32'd0);
      send_request(OP_ACK, 32'h7fffffff, 32'hffffffff, 32'd0);
      send_request(OP_QUERY, 32'd0, 32'd0, 32'd10);
      send_request(OP_ACK, 32'h7ffffffe, 32'hffffffff, 32'hffffffff);
      // bound checks on the window
      send_request(OP_QUERY, 32'd0, 32'd0, 32'd0);
      send_request(OP_QUERY, 32'd0, 32'd0, 32'd1);
      send_request(OP_QUERY, 32'd0, 32'd0, 32'h3fffffff);
      send_request(OP_QUERY, 32'd0, 32'd0, 32'h40000000);
      send_request(OP_QUERY, 32'd0, 32'd0, 32'hffffffff);
      send_request(OP_QUERY, 32'd0, 32'd0, 32'd1000);
      // rate truncated to 32 bits
      send_request(OP_ACK, 32'd999999, 32'hffffffff, 32'd0);
      send_request(OP_QUERY, 32'd0, 32'd0, 32'd100);
      send_request(OP_ACK, 32'd1000000, 32'd1, 32'd0);
      send_request(OP_ACK, 32'h7ffffffe, 32'd1, 32'd0);
      send_request(OP_QUERY, 32'hffffffff, 32'hffffffff, 32'd7);

      for (int i = 0; i < PHASE_ITEMS; i++) send_random(0);
      send_pct = 65;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random(1);

      // long response hold while requests keep coming
      send_pct = 0;
      hold_seq++;
      for (int i = 0; i < BURST_ITEMS; i++) send_random(1);

      stall_pct = 65;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random(2);
      send_pct = 12;
      stall_pct = 12;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random(3);

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (80) @(posedge clock);

      $display("covered %0d requests: %0d ack samples and %0d loss queries", ack_sent + query_sent,
               ack_sent, query_sent);
      $display("%0d responses checked, %0d samples updated the estimate, one long response hold",
               rsp_count, taken_count);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/bdp_sst_pkg.sv
rtl/bdp_sst_if.sv
rtl/bdp_sst_div.sv
rtl/bdp_slow_start_threshold_top.sv
test/bdp_sst_checker.sv
test/bdp_slow_start_threshold_top_test.sv
